// ----- hw/rtl/schedule_window_matcher_assert.svh -----
// Assertion macros for the schedule window matcher.
`ifndef SCHEDULE_WINDOW_MATCHER_ASSERT_SVH
`define SCHEDULE_WINDOW_MATCHER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SWM_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When trig holds, cond must hold in the next cycle.
`define SWM_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- hw/rtl/swm_pkg.sv -----
// Types, constants and helpers shared by the schedule window matcher.
package swm_pkg;

  localparam int MAX_WINDOWS  = 16;
  localparam int LAMP_ID_BITS = 8;
  localparam int WIN_IDX_W    = $clog2(MAX_WINDOWS);
  localparam int WIN_CNT_W    = WIN_IDX_W + 1;
  localparam int MOD_W        = 11;   // minute of day, also for unchecked hour/minute

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HOUR   = 3'd1,
    ST_MINUTE = 3'd2,
    ST_ZERO   = 3'd3,
    ST_INDEX  = 3'd4
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [4:0] entry_index;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic       lamp_on;
    logic [7:0] lamp_id;
    logic       lamp_any;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [3:0] window_index;
    logic       window_lamp_on;
  } res_t;

  typedef struct packed {
    logic [MOD_W-1:0]        start;
    logic [MOD_W-1:0]        stop;
    logic                    on;
    logic [LAMP_ID_BITS-1:0] lamp;
    logic                    any;
  } entry_t;

  // Request token that walks the cell chain.
  typedef struct packed {
    cmd_e                    cmd;
    logic                    wr_en;
    logic [WIN_IDX_W-1:0]    idx;
    entry_t                  entry;
    logic [MOD_W-1:0]        now;
    logic [WIN_CNT_W-1:0]    limit;
    logic [WIN_IDX_W-1:0]    pos;
    status_e                 status;
    logic                    found;
    logic [WIN_IDX_W-1:0]    widx;
    logic                    won;
  } tok_t;

  // hour*60 + minute as (h<<6) - (h<<2) + m
  function automatic logic [MOD_W-1:0] minute_of_day(input logic [4:0] h,
                                                      input logic [5:0] m);
    logic [MOD_W-1:0] hx;
    hx = MOD_W'(h);
    return (hx << 6) - (hx << 2) + MOD_W'(m);
  endfunction

endpackage

// ----- hw/rtl/swm_cell.sv -----
// One table slot of the matcher chain: stores an entry, checks the passing request.
module swm_cell import swm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic tok_valid_in,
  input  tok_t tok_in,
  output logic tok_valid_out,
  output tok_t tok_out
);

  entry_t entry;
  logic   covers;
  logic   lamp_ok;
  logic   hit;
  logic   wr;
  tok_t   tok_next;

  always_comb begin
    // half-open window, wraps past midnight when start is not below stop
    if (entry.start < entry.stop) begin
      covers = (tok_in.now >= entry.start) && (tok_in.now < entry.stop);
    end else begin
      covers = (tok_in.now >= entry.start) || (tok_in.now < entry.stop);
    end
    lamp_ok = tok_in.entry.any || entry.any || (entry.lamp == tok_in.entry.lamp);
    hit = (tok_in.cmd == CMD_LOOKUP) && !tok_in.found &&
          ({1'b0, tok_in.pos} < tok_in.limit) && covers && lamp_ok;
    wr  = (tok_in.cmd == CMD_WRITE) && tok_in.wr_en && (tok_in.idx == tok_in.pos);
    tok_next     = tok_in;
    tok_next.pos = tok_in.pos + 1'b1;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.widx  = tok_in.pos;
      tok_next.won   = entry.on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (adv && tok_valid_in && wr) begin
      entry <= tok_in.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else if (adv) begin
      tok_valid_out <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- hw/rtl/schedule_window_matcher.sv -----
// Path: request registered at the head on accept, then through the 16 cells, then the output register.
// Throughput: one request in flight; next request accepted the cycle after the result
// leaves the last cell. The 16-cell chain sets the pace: the request visits one table
// slot per cycle while the chain is not held by a stalled output.
// Reset (rst, synchronous): table entries cleared to zero, window_count to 0, chain empty.
module schedule_window_matcher import swm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

`include "schedule_window_matcher_assert.svh"

  logic [4:0]             window_count;
  logic                   busy;
  logic                   accept;
  logic                   adv;
  logic                   leave;
  logic [MAX_WINDOWS:0]   tok_valid;
  tok_t                   tok [0:MAX_WINDOWS];
  tok_t                   head_next;
  status_e                wr_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      window_count <= cfg_data;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  // chain holds only while the finished request cannot enter the output register
  assign adv      = !(tok_valid[MAX_WINDOWS] && out_valid && out_stall);
  assign leave    = tok_valid[MAX_WINDOWS] && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (leave) begin
      busy <= 1'b0;
    end
  end

  // validation, priority as listed
  always_comb begin
    priority if (32'(in_data.entry_index) >= MAX_WINDOWS) begin
      wr_status = ST_INDEX;
    end else if (in_data.start_hour > MAX_HOUR || in_data.end_hour > MAX_HOUR) begin
      wr_status = ST_HOUR;
    end else if (in_data.start_minute > MAX_MINUTE || in_data.end_minute > MAX_MINUTE) begin
      wr_status = ST_MINUTE;
    end else if (in_data.start_hour == in_data.end_hour &&
                 in_data.start_minute == in_data.end_minute) begin
      wr_status = ST_ZERO;
    end else begin
      wr_status = ST_OK;
    end
  end

  always_comb begin
    head_next             = '0;
    head_next.cmd         = cmd_e'(in_data.cmd);
    head_next.status      = (in_data.cmd == CMD_LOOKUP) ? ST_OK : wr_status;
    head_next.wr_en       = (in_data.cmd == CMD_WRITE) && (wr_status == ST_OK);
    head_next.idx         = in_data.entry_index[WIN_IDX_W-1:0];
    head_next.entry.start = minute_of_day(in_data.start_hour, in_data.start_minute);
    head_next.entry.stop  = minute_of_day(in_data.end_hour, in_data.end_minute);
    head_next.entry.on    = in_data.lamp_on;
    head_next.entry.lamp  = in_data.lamp_id[LAMP_ID_BITS-1:0];
    head_next.entry.any   = in_data.lamp_any;
    head_next.now         = minute_of_day(in_data.now_hour, in_data.now_minute);
    head_next.limit       = (32'(window_count) >= MAX_WINDOWS) ?
                            WIN_CNT_W'(MAX_WINDOWS) : WIN_CNT_W'(window_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid[0] <= 1'b0;
    end else if (adv) begin
      tok_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok[0] <= head_next;
    end
  end

  for (genvar k = 0; k < MAX_WINDOWS; k++) begin : g_cell
    swm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .tok_valid_in (tok_valid[k]),
      .tok_in       (tok[k]),
      .tok_valid_out(tok_valid[k+1]),
      .tok_out      (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (leave) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave) begin
      out_data.status         <= tok[MAX_WINDOWS].status;
      out_data.found          <= tok[MAX_WINDOWS].found;
      out_data.window_index   <= 4'(tok[MAX_WINDOWS].widx);
      out_data.window_lamp_on <= tok[MAX_WINDOWS].won;
    end
  end

  `SWM_CHECK(a_one_in_flight, $countones(tok_valid) <= 1, "more than one request in chain")
  `SWM_CHECK(a_busy_tracks_chain, busy == (|tok_valid), "busy flag out of step with chain")
  `SWM_CHECK_NEXT(a_accept_enters, accept, tok_valid[0], "accepted request missing at head")
  `SWM_CHECK_NEXT(a_hold_at_end, tok_valid[MAX_WINDOWS] && out_valid && out_stall,
                  tok_valid[MAX_WINDOWS], "finished request dropped while output stalled")

endmodule
